// ----- src/mvp_pkg.sv -----
// Shared types, constants and the CRC-16/X.25 step for the MAVLink v1 frame packer.
package mvp_pkg;

	localparam logic [7:0] STX_BYTE = 8'hFE;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [7:0] BYTE_MASK = 8'hFF;
	localparam int QUEUE_DEPTH_DEFAULT = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [2:0] HDR_FIRST_IDX = 3'd1;
	localparam logic [2:0] HDR_LAST_IDX = 3'd5;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_ID = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_ID = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE = 2'd2;

	localparam logic [2:0] HDR_IDX_LENGTH = 3'd1;
	localparam logic [2:0] HDR_IDX_SEQUENCE = 3'd2;
	localparam logic [2:0] HDR_IDX_SYSTEM = 3'd3;
	localparam logic [2:0] HDR_IDX_COMPONENT = 3'd4;
	localparam logic [2:0] HDR_IDX_MESSAGE = 3'd5;

	typedef enum logic {
		CMD_START,
		CMD_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic last;
		logic [7:0] arg;
		logic [7:0] msg_id;
		logic [7:0] extra;
	} cmd_t;

	typedef struct packed {
		logic [7:0] system_id;
		logic [7:0] component_id;
		logic [7:0] sequence_number;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_CRC_LO,
		ST_CRC_HI
	} back_state_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

endpackage

// ----- src/mvp_front.sv -----
// Input side: accepts beats, tracks the open frame and queues start and payload commands.
module mvp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,  // message id, length, CRC extra, payload byte
	input  logic          s_tuser,  // op
	input  logic          q_full,
	output logic          q_push,
	output mvp_pkg::cmd_t q_wdata
);
	import mvp_pkg::*;

	logic       open_q;
	logic [7:0] remaining_q;
	logic       accept;
	logic [7:0] msg_id;
	logic [7:0] length;
	logic [7:0] extra;
	logic [7:0] data;

	assign msg_id = s_tdata[7:0];
	assign length = s_tdata[15:8];
	assign extra = s_tdata[23:16];
	assign data = s_tdata[31:24];

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign q_push = accept && ((s_tuser == OP_START) || open_q);

	always_comb begin
		q_wdata.msg_id = msg_id;
		q_wdata.extra = extra;
		if (s_tuser == OP_START) begin
			q_wdata.kind = CMD_START;
			q_wdata.last = (length == 8'h00);
			q_wdata.arg = length;
		end else begin
			q_wdata.kind = CMD_DATA;
			q_wdata.last = (remaining_q == 8'h01);
			q_wdata.arg = data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			remaining_q <= 8'h00;
		end else if (accept) begin
			if (s_tuser == OP_START) begin
				open_q <= (length != 8'h00);
				remaining_q <= length;
			end else if (open_q) begin
				remaining_q <= remaining_q - 8'h01;
				if (remaining_q == 8'h01) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/mvp_queue.sv -----
// Small command queue between the input side and the byte sequencer.
module mvp_queue #(
	parameter int DEPTH = mvp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvp_pkg::cmd_t wdata,
	input  logic          pop,
	output mvp_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import mvp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/mvp_back.sv -----
// Byte sequencer: emits header, payload and CRC bytes and keeps the running CRC.
module mvp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mvp_pkg::cfg_t cfg,
	input  mvp_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,  // out_byte
	output logic          m_tlast,  // frame_end
	output logic          m_tuser   // run_last
);
	import mvp_pkg::*;

	back_state_t state_q, state_d;
	logic [2:0]  idx_q, idx_d;
	cmd_t        cur_q, cur_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  extra_q, extra_d;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;
	logic        out_last_q;

	logic        advance;
	logic        produce;
	logic [7:0]  byte_d;
	logic        end_d;
	logic        last_d;
	logic [7:0]  hdr_byte;
	logic [15:0] crc_final;

	assign advance = !out_valid_q || m_tready;
	assign crc_final = crc_fold(crc_q, extra_q);

	always_comb begin
		case (idx_q)
			HDR_IDX_LENGTH: hdr_byte = cur_q.arg;
			HDR_IDX_SEQUENCE: hdr_byte = cfg.sequence_number;
			HDR_IDX_SYSTEM: hdr_byte = cfg.system_id;
			HDR_IDX_COMPONENT: hdr_byte = cfg.component_id;
			HDR_IDX_MESSAGE: hdr_byte = cur_q.msg_id;
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cur_d = cur_q;
		crc_d = crc_q;
		extra_d = extra_q;
		q_pop = 1'b0;
		produce = 1'b0;
		byte_d = 8'h00;
		end_d = 1'b0;
		last_d = 1'b0;
		if (advance) begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						q_pop = 1'b1;
						produce = 1'b1;
						if (head.kind == CMD_START) begin
							byte_d = STX_BYTE;
							cur_d = head;
							extra_d = head.extra;
							crc_d = CRC_SEED;
							idx_d = HDR_FIRST_IDX;
							state_d = ST_HDR;
						end else begin
							byte_d = head.arg;
							crc_d = crc_fold(crc_q, head.arg);
							last_d = !head.last;
							state_d = head.last ? ST_CRC_LO : ST_IDLE;
						end
					end
				end
				ST_HDR: begin
					produce = 1'b1;
					byte_d = hdr_byte;
					crc_d = crc_fold(crc_q, hdr_byte);
					if (idx_q == HDR_LAST_IDX) begin
						if (cur_q.arg == 8'h00) begin
							state_d = ST_CRC_LO;
						end else begin
							last_d = 1'b1;
							state_d = ST_IDLE;
						end
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
				ST_CRC_LO: begin
					produce = 1'b1;
					byte_d = crc_final[7:0];
					crc_d = crc_final;
					state_d = ST_CRC_HI;
				end
				ST_CRC_HI: begin
					produce = 1'b1;
					byte_d = crc_q[15:8];
					end_d = 1'b1;
					last_d = 1'b1;
					crc_d = CRC_SEED;
					state_d = ST_IDLE;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= HDR_FIRST_IDX;
			crc_q <= CRC_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			crc_q <= crc_d;
			if (advance) begin
				out_valid_q <= produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		extra_q <= extra_d;
		if (advance && produce) begin
			out_byte_q <= byte_d;
			out_end_q <= end_d;
			out_last_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_end_q;
	assign m_tuser = out_last_q;

endmodule

// ----- src/mavlink_v1_frame_packer.sv -----
// Top level of the MAVLink v1 frame packer: configuration registers, queue and sequencer.
// The first byte of an item passes through the command queue and then the output register.
// The sequencer emits one byte per cycle unless m_tready stalls it; a payload beat yields its byte,
// a start beat STX and five header bytes, plus both CRC bytes for an empty payload, and a closing
// payload beat its byte and both CRC bytes. The command queue lets input beats be taken while
// header or CRC bytes are still going out. Reset is asynchronous and active low; it empties the
// queue, closes any frame and loads system id 1, component id 1 and sequence 0.
module mavlink_v1_frame_packer #(
	parameter int QUEUE_DEPTH = mvp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // message id, length, CRC extra, payload byte
	input  logic                           s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // out_byte
	output logic                           m_tlast,  // frame_end
	output logic                           m_tuser,  // run_last
	input  logic                           cfg_we,
	input  logic [mvp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mvp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mvp_pkg::*;

	cfg_t cfg_q;
	cmd_t q_wdata;
	cmd_t q_head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.system_id <= 8'h01;
			cfg_q.component_id <= 8'h01;
			cfg_q.sequence_number <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYSTEM_ID: cfg_q.system_id <= cfg_wdata;
				REG_COMPONENT_ID: cfg_q.component_id <= cfg_wdata;
				REG_SEQUENCE: cfg_q.sequence_number <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	mvp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	mvp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	mvp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue read while empty");

	a_frame_end_closes_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("frame end beat is not the last beat of its item");

endmodule
